// ===== hw/rtl/cfbp_pkg.sv =====
package cfbp_pkg;

    // field widths
    localparam int MODE_W   = 2;
    localparam int ID_W     = 29;
    localparam int LEN_W    = 7;
    localparam int PAY_W    = 64;
    localparam int FILL_W   = 7;
    localparam int STATUS_W = 3;

    // default table depth
    localparam int MAX_FRAMES_DEF = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_SEND  = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_ZERO_LEN = 3'd2,
        ST_FULL     = 3'd3,
        ST_UNKNOWN  = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;   // request taken, latch its fields
        logic lookup;    // match identifier, pick slot, read entry
        logic exec;      // update entry and load result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // result register can take a new result
    } sts_t;

endpackage

// ===== hw/rtl/cfbp_ctrl.sv =====
module cfbp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cfbp_pkg::sts_t   sts,
    output cfbp_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        IDLE,
        MATCH,
        EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        s_ready = (state_reg == IDLE) || ((state_reg == EXEC) && sts.out_free);
        cmd.load_in = s_valid && s_ready;
        cmd.lookup  = (state_reg == MATCH);
        cmd.exec    = (state_reg == EXEC) && sts.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    state_next = MATCH;
                end
            end
            MATCH: begin
                state_next = EXEC;
            end
            EXEC: begin
                if (sts.out_free) begin
                    state_next = s_valid ? MATCH : IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/cfbp_dpath.sv =====
module cfbp_dpath #(
    parameter int MAX_FRAMES = cfbp_pkg::MAX_FRAMES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cfbp_pkg::cmd_t                 cmd,
    output cfbp_pkg::sts_t                 sts,
    input  logic [cfbp_pkg::MODE_W-1:0]    s_mode,
    input  logic [cfbp_pkg::ID_W-1:0]      s_frame_id,
    input  logic [cfbp_pkg::LEN_W-1:0]     s_bit_len,
    input  logic [cfbp_pkg::PAY_W-1:0]     s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cfbp_pkg::STATUS_W-1:0]  m_status,
    output logic                           m_frame_valid,
    output logic [cfbp_pkg::ID_W-1:0]      m_out_id,
    output logic [cfbp_pkg::PAY_W-1:0]     m_payload,
    output logic [cfbp_pkg::FILL_W-1:0]    m_bits_used
);

    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int MEM_W  = cfbp_pkg::FILL_W + cfbp_pkg::PAY_W;
    localparam int SUM_W  = cfbp_pkg::LEN_W + 1;

    // latched request
    logic [cfbp_pkg::MODE_W-1:0] mode_reg;
    logic [cfbp_pkg::ID_W-1:0]   id_reg;
    logic [cfbp_pkg::LEN_W-1:0]  len_reg;
    logic [cfbp_pkg::PAY_W-1:0]  value_reg;

    // table: valid and identifier in flops, fill and payload in memory
    logic [MAX_FRAMES-1:0]       valid_reg;
    logic [cfbp_pkg::ID_W-1:0]   ident_reg [MAX_FRAMES];
    logic [MEM_W-1:0]            frame_mem [MAX_FRAMES];

    // lookup results
    logic [SLOT_W-1:0]           slot_reg;
    logic                        hit_reg;
    logic                        free_reg;
    logic [MEM_W-1:0]            rd_reg;

    // result register
    logic                        m_valid_reg;
    logic [cfbp_pkg::STATUS_W-1:0] status_reg;
    logic                        fv_reg;
    logic [cfbp_pkg::ID_W-1:0]   oid_reg;
    logic [cfbp_pkg::PAY_W-1:0]  pay_reg;
    logic [cfbp_pkg::FILL_W-1:0] used_reg;

    logic [MAX_FRAMES-1:0]       hit_vec;
    logic [MAX_FRAMES-1:0]       free_vec;
    logic [MAX_FRAMES-1:0]       free_1h;
    logic [SLOT_W-1:0]           hit_idx;
    logic [SLOT_W-1:0]           free_idx;
    logic [SLOT_W-1:0]           slot_next;

    logic [cfbp_pkg::FILL_W-1:0] fill_rd;
    logic [cfbp_pkg::PAY_W-1:0]  pay_rd;
    logic [cfbp_pkg::FILL_W-1:0] eff_fill;
    logic [cfbp_pkg::PAY_W-1:0]  eff_pay;
    logic [SUM_W-1:0]            sum;
    logic [cfbp_pkg::PAY_W-1:0]  mask;
    logic [cfbp_pkg::PAY_W-1:0]  packed_pay;

    logic                        wr_en;
    logic                        create;
    logic [cfbp_pkg::FILL_W-1:0] wr_fill;
    logic [cfbp_pkg::PAY_W-1:0]  wr_pay;
    cfbp_pkg::status_t           status_next;
    logic                        fv_next;
    logic [cfbp_pkg::ID_W-1:0]   oid_next;
    logic [cfbp_pkg::PAY_W-1:0]  pay_next;
    logic [cfbp_pkg::FILL_W-1:0] used_next;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg  <= s_mode;
            id_reg    <= s_frame_id;
            len_reg   <= s_bit_len;
            value_reg <= s_value;
        end
    end

    // identifier match; at most one valid entry holds a given id
    always_comb begin
        free_vec = ~valid_reg;
        free_1h  = free_vec & (~free_vec + MAX_FRAMES'(1));
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            hit_vec[i] = valid_reg[i] && (ident_reg[i] == id_reg);
        end
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (hit_vec[i]) begin
                hit_idx = hit_idx | SLOT_W'(i);
            end
            if (free_1h[i]) begin
                free_idx = free_idx | SLOT_W'(i);
            end
        end
        slot_next = (|hit_vec) ? hit_idx : free_idx;
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            slot_reg <= slot_next;
            hit_reg  <= |hit_vec;
            free_reg <= |free_vec;
            rd_reg   <= frame_mem[slot_next];
        end
    end

    // read-modify-write of the selected entry
    always_comb begin
        fill_rd    = rd_reg[MEM_W-1 -: cfbp_pkg::FILL_W];
        pay_rd     = rd_reg[cfbp_pkg::PAY_W-1:0];
        eff_fill   = hit_reg ? fill_rd : '0;
        eff_pay    = hit_reg ? pay_rd : '0;
        sum        = {1'b0, eff_fill} + {1'b0, len_reg};
        mask       = ~({cfbp_pkg::PAY_W{1'b1}} << len_reg);
        packed_pay = eff_pay | ((value_reg & mask) << eff_fill);

        wr_en       = 1'b0;
        create      = 1'b0;
        wr_fill     = eff_fill;
        wr_pay      = eff_pay;
        status_next = cfbp_pkg::ST_OK;
        fv_next     = 1'b0;
        oid_next    = '0;
        pay_next    = '0;
        used_next   = '0;

        case (cfbp_pkg::mode_t'(mode_reg))
            cfbp_pkg::MODE_ADD: begin
                if (len_reg == '0) begin
                    status_next = cfbp_pkg::ST_ZERO_LEN;
                    used_next   = eff_fill;
                end else if (!hit_reg && !free_reg) begin
                    status_next = cfbp_pkg::ST_FULL;
                end else begin
                    create = !hit_reg;
                    wr_en  = 1'b1;
                    if (sum > SUM_W'(cfbp_pkg::PAY_W)) begin
                        status_next = cfbp_pkg::ST_OVERFLOW;
                        used_next   = eff_fill;
                    end else begin
                        wr_fill   = sum[cfbp_pkg::FILL_W-1:0];
                        wr_pay    = packed_pay;
                        used_next = sum[cfbp_pkg::FILL_W-1:0];
                    end
                end
            end
            cfbp_pkg::MODE_CLEAR: begin
                if (!hit_reg && !free_reg) begin
                    status_next = cfbp_pkg::ST_FULL;
                end else begin
                    create  = !hit_reg;
                    wr_en   = 1'b1;
                    wr_fill = '0;
                    wr_pay  = '0;
                end
            end
            cfbp_pkg::MODE_SEND: begin
                if (hit_reg) begin
                    fv_next   = 1'b1;
                    oid_next  = id_reg;
                    pay_next  = pay_rd;
                    used_next = fill_rd;
                end else begin
                    status_next = cfbp_pkg::ST_UNKNOWN;
                end
            end
            default: begin
                status_next = cfbp_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            frame_mem[slot_reg] <= {wr_fill, wr_pay};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && create) begin
            ident_reg[slot_reg] <= id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.exec && create) begin
            valid_reg[slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            fv_reg     <= fv_next;
            oid_reg    <= oid_next;
            pay_reg    <= pay_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free  = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_frame_valid = fv_reg;
    assign m_out_id      = oid_reg;
    assign m_payload     = pay_reg;
    assign m_bits_used   = used_reg;

`ifndef ASSERT_OFF
    a_lookup_follows_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> cmd.lookup)
        else $error("lookup did not follow a taken request");

    a_exec_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> sts.out_free)
        else $error("execute while result register busy");

    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lookup |-> $onehot0(hit_vec))
        else $error("identifier held by more than one entry");

    a_table_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> $countones(valid_reg) >= $past($countones(valid_reg)))
        else $error("table entry lost");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid_reg)
        else $error("executed request gave no result");
`endif

endmodule

// ===== hw/rtl/can_frame_bit_packer.sv =====
// can frame bit packer: keeps a table of up to MAX_FRAMES frames keyed by
// identifier, each with a 64-bit payload and a fill count in bits. an add
// request appends the low bit_len bits of value at the current fill, a clear
// request empties the frame and a send request returns the stored frame;
// add and clear create a missing entry, and every request gives exactly one
// result with a status. a request passes through an identifier match
// state that compares every stored identifier and reads the selected entry
// from the payload memory, then an execute state that does the
// read-modify-write and loads the result register. the next request is
// taken in the execute cycle, while the previous request finishes. a result
// waiting on m_ready holds the execute cycle and so stalls the input

module can_frame_bit_packer #(
    parameter int MAX_FRAMES = cfbp_pkg::MAX_FRAMES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cfbp_pkg::MODE_W-1:0]    s_mode,
    input  logic [cfbp_pkg::ID_W-1:0]      s_frame_id,
    input  logic [cfbp_pkg::LEN_W-1:0]     s_bit_len,
    input  logic [cfbp_pkg::PAY_W-1:0]     s_value,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cfbp_pkg::STATUS_W-1:0]  m_status,
    output logic                           m_frame_valid,
    output logic [cfbp_pkg::ID_W-1:0]      m_out_id,
    output logic [cfbp_pkg::PAY_W-1:0]     m_payload,
    output logic [cfbp_pkg::FILL_W-1:0]    m_bits_used
);

    // command and status between sequencer and datapath
    cfbp_pkg::cmd_t cmd;
    cfbp_pkg::sts_t sts;

    // sequencer: idle, match, execute
    cfbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // frame table, packing logic and result register
    cfbp_dpath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_mode        (s_mode),
        .s_frame_id    (s_frame_id),
        .s_bit_len     (s_bit_len),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_frame_valid (m_frame_valid),
        .m_out_id      (m_out_id),
        .m_payload     (m_payload),
        .m_bits_used   (m_bits_used)
    );

endmodule
